FILE: rtl/core/qrot_pkg.sv
// shared types, codes and constants for the query route override table
`default_nettype none

package qrot_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int REGION_BITS   = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam int CMD_W    = 2;
    localparam int KIND_W   = 3;
    localparam int REGION_W = 16;
    localparam int BE_W     = 2;
    localparam int SRC_W    = 2;

    // commands
    localparam logic [CMD_W-1:0] CMD_ROUTE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // backends
    localparam logic [BE_W-1:0] BE_NONE  = 2'd0;
    localparam logic [BE_W-1:0] BE_SWEEP = 2'd1;
    localparam logic [BE_W-1:0] BE_BVH   = 2'd2;
    localparam logic [BE_W-1:0] BE_GRID  = 2'd3;

    // match sources
    localparam logic [SRC_W-1:0] SRC_EXACT   = 2'd0;
    localparam logic [SRC_W-1:0] SRC_GLOBAL  = 2'd1;
    localparam logic [SRC_W-1:0] SRC_DEFAULT = 2'd2;

    // query kinds
    localparam logic [KIND_W-1:0] KIND_RAYCAST   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FRUSTUM   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BOX       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BROAD     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NEAREST   = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [KIND_W-1:0]   query_kind;
        logic [REGION_W-1:0] region_id;
        logic [BE_W-1:0]     new_backend;
    } t_query;

    typedef struct packed {
        logic [BE_W-1:0]  chosen_backend;
        logic [SRC_W-1:0] match_source;
        logic             table_full;
    } t_result;

    // word walking down the cell chain
    typedef struct packed {
        logic                   vld;
        logic [CMD_W-1:0]       cmd;
        logic [KIND_W-1:0]      kind;
        logic [REGION_BITS-1:0] region;
        logic [REGION_BITS-1:0] glob;
        logic [BE_W-1:0]        backend;
        logic                   exact_hit;
        logic [BE_W-1:0]        exact_be;
        logic                   glob_hit;
        logic [BE_W-1:0]        glob_be;
        logic                   free_hit;
        logic [IDX_W-1:0]       free_idx;
    } t_scan;

    // insert broadcast into the chosen free cell
    typedef struct packed {
        logic                   en;
        logic [IDX_W-1:0]       idx;
        logic [KIND_W-1:0]      kind;
        logic [REGION_BITS-1:0] region;
        logic [BE_W-1:0]        backend;
    } t_wr;

    function automatic logic [BE_W-1:0] kind_default(input logic [KIND_W-1:0] kind);
        logic [BE_W-1:0] be;
        case (kind) inside
            KIND_RAYCAST, KIND_FRUSTUM, KIND_BOX: be = BE_BVH;
            KIND_BROAD:                           be = BE_SWEEP;
            KIND_NEAREST:                         be = BE_GRID;
            default:                              be = BE_NONE;
        endcase
        return be;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/query_route_override_table_top.sv
// top level: command intake, cell chain, result resolve and output buffering
`default_nettype none

// Route/override table of TABLE_ENTRIES cells. Each accepted word walks the cell
// chain one cell per cycle, behind an input register, and the next word is
// taken once its result has left the chain and the skid is empty. A finished
// result waits in an output register plus a one-word skid so the chain can
// take the next word while it is held. Set updates and set-to-none removals
// happen in the matching cell as the word passes, and a clear empties every
// cell; an insert goes to the lowest free cell when the word leaves the chain.
// No clearing pass is needed after reset.

module query_route_override_table_top
    import qrot_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [REGION_W-1:0] i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire t_query              i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output t_result                  o_out_data
);

    logic                r_busy;
    logic [REGION_W-1:0] r_glob;
    t_scan               r_tok0;
    t_scan               n_tok0;
    logic                r_out_vld;
    t_result             r_out;
    logic                r_skid_vld;
    t_result             r_skid;

    t_scan               tok [TABLE_ENTRIES+1];
    t_scan               tok_last;
    t_wr                 wr;
    t_result             res;
    logic                in_acc;
    logic [TABLE_ENTRIES-1:0] w_tok_vld;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_busy && !r_skid_vld;
    assign in_acc      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glob <= '0;
        end else if (i_cfg_valid) begin
            r_glob <= i_cfg_data;
        end
    end

    always_comb begin
        n_tok0 = '0;
        if (in_acc) begin
            n_tok0.vld     = 1'b1;
            n_tok0.cmd     = i_in_data.cmd;
            n_tok0.kind    = i_in_data.query_kind;
            n_tok0.region  = i_in_data.region_id[REGION_BITS-1:0];
            n_tok0.glob    = r_glob[REGION_BITS-1:0];
            n_tok0.backend = i_in_data.new_backend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok0 <= '0;
        end else begin
            r_tok0 <= n_tok0;
        end
    end

    assign tok[0] = r_tok0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        qrot_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_tok   (tok[g]),
            .i_wr    (wr),
            .o_tok   (tok[g+1])
        );
        assign w_tok_vld[g] = tok[g].vld;
    end

    assign tok_last = tok[TABLE_ENTRIES];

    // resolve the result and any insert once the word leaves the chain
    always_comb begin
        res        = '0;
        wr         = '0;
        wr.idx     = tok_last.free_idx;
        wr.kind    = tok_last.kind;
        wr.region  = tok_last.region;
        wr.backend = tok_last.backend;
        case (tok_last.cmd)
            CMD_ROUTE: begin
                if (tok_last.exact_hit) begin
                    res.chosen_backend = tok_last.exact_be;
                    res.match_source   = SRC_EXACT;
                end else if (tok_last.glob_hit && tok_last.region != tok_last.glob) begin
                    res.chosen_backend = tok_last.glob_be;
                    res.match_source   = SRC_GLOBAL;
                end else begin
                    res.chosen_backend = kind_default(tok_last.kind);
                    res.match_source   = SRC_DEFAULT;
                end
            end
            CMD_SET: begin
                if (tok_last.backend != BE_NONE && !tok_last.exact_hit) begin
                    wr.en          = tok_last.vld && tok_last.free_hit;
                    res.table_full = !tok_last.free_hit;
                end
            end
            default: begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_busy <= 1'b1;
            end else if (tok_last.vld) begin
                r_busy <= 1'b0;
            end
            // the skid is always empty when a word leaves the chain
            if (tok_last.vld) begin
                if (!r_out_vld || i_out_ready) begin
                    r_out     <= res;
                    r_out_vld <= 1'b1;
                end else begin
                    r_skid     <= res;
                    r_skid_vld <= 1'b1;
                end
            end else if (r_out_vld && i_out_ready) begin
                if (r_skid_vld) begin
                    r_out      <= r_skid;
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out_vld <= 1'b0;
                end
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef SYNTH
    // only one word walks the chain at a time
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_tok_vld, tok_last.vld}))
        else $error("more than one word in the cell chain");

    // an idle block has an empty chain
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (w_tok_vld == '0 && !tok_last.vld))
        else $error("word in chain while not busy");

    // skid holds a word only behind a full output register
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid full with output register empty");

    // a word leaving the chain clears busy
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_last.vld |=> !r_busy)
        else $error("busy stuck after result");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/qrot_cell.sv
// one table entry with its compare logic and its stage of the scan chain
`default_nettype none

module qrot_cell
    import qrot_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [IDX_W-1:0] i_idx,
    input  wire t_scan            i_tok,
    input  wire t_wr              i_wr,
    output t_scan                 o_tok
);

    logic                   r_valid;
    logic [KIND_W-1:0]      r_kind;
    logic [REGION_BITS-1:0] r_region;
    logic [BE_W-1:0]        r_backend;
    t_scan                  r_tok;
    t_scan                  n_tok;

    logic m_exact;
    logic m_glob;
    logic wr_hit;
    logic set_hit;

    assign m_exact = i_tok.vld && r_valid && (r_kind == i_tok.kind)
                     && (r_region == i_tok.region);
    assign m_glob  = i_tok.vld && r_valid && (r_kind == i_tok.kind)
                     && (r_region == i_tok.glob);
    assign wr_hit  = i_wr.en && (i_wr.idx == i_idx);
    assign set_hit = m_exact && (i_tok.cmd == CMD_SET);

    always_comb begin
        n_tok = i_tok;
        if (m_exact) begin
            n_tok.exact_hit = 1'b1;
            n_tok.exact_be  = r_backend;
        end
        if (m_glob && !i_tok.glob_hit) begin
            n_tok.glob_hit = 1'b1;
            n_tok.glob_be  = r_backend;
        end
        // lowest free slot wins since the word visits cells in order
        if (i_tok.vld && !r_valid && !i_tok.free_hit) begin
            n_tok.free_hit = 1'b1;
            n_tok.free_idx = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_tok <= n_tok;
            if (wr_hit) begin
                r_valid <= 1'b1;
            end else if (i_tok.vld && i_tok.cmd == CMD_CLEAR) begin
                r_valid <= 1'b0;
            end else if (set_hit && i_tok.backend == BE_NONE) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_hit) begin
            r_kind    <= i_wr.kind;
            r_region  <= i_wr.region;
            r_backend <= i_wr.backend;
        end else if (set_hit && i_tok.backend != BE_NONE) begin
            r_backend <= i_tok.backend;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire
